// ===== sv/i8080_move_and_addsub_execute_assert.svh =====
// Assertion helpers for the move and add/subtract execute block.
// Each macro expects clk and rst_n in scope.
`ifndef I8080_MOVE_AND_ADDSUB_EXECUTE_ASSERT_SVH
`define I8080_MOVE_AND_ADDSUB_EXECUTE_ASSERT_SVH

// Check a consequence in the same cycle.
`define I8080MAS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i8080mas assertion failed");

// Check a consequence in the next cycle.
`define I8080MAS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i8080mas assertion failed");

`endif

// ===== sv/i8080mas_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i8080mas_pkg
// Shared types and opcode constants for the move and add/subtract execute block.
// ----------------------------------------------------------------------------
package i8080mas_pkg;

    localparam int NUM_GPR = 6;

    localparam logic [7:0] OP_NOP = 8'h00;
    localparam logic [7:0] OP_STC = 8'h37;
    localparam logic [7:0] OP_CMC = 8'h3F;
    localparam logic [7:0] OP_HLT = 8'h76;
    localparam logic [7:0] OP_DI  = 8'hF3;
    localparam logic [7:0] OP_EI  = 8'hFB;

    // Top bits of the MOV and add/subtract opcode groups
    localparam logic [1:0] GRP_MOV    = 2'b01;
    localparam logic [2:0] GRP_ADDSUB = 3'b100;

    // Operand codes in the low (source) and middle (destination) fields
    localparam logic [2:0] OPND_MEM = 3'd6;
    localparam logic [2:0] OPND_ACC = 3'd7;

    localparam logic [3:0] REG_H = 4'd4;
    localparam logic [3:0] REG_L = 4'd5;

    typedef enum logic [1:0] {
        ALU_ADD = 2'd0,
        ALU_ADC = 2'd1,
        ALU_SUB = 2'd2,
        ALU_SBB = 2'd3
    } alu_op_t;

    typedef struct packed {
        logic p;
        logic s;
        logic z;
        logic ac;
        logic c;
    } flags_t;

    typedef struct packed {
        logic [7:0]                acc;
        logic [NUM_GPR-1:0][7:0]   gpr;   // index 0..5 = B,C,D,E,H,L
        flags_t                    flags;
        logic                      ie;
    } arch_state_t;

    typedef struct packed {
        logic        mem_write;
        logic [15:0] mem_address;
        logic [7:0]  mem_write_data;
        logic        implemented;
    } exec_info_t;

endpackage

// ===== sv/i8080_move_and_addsub_execute.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i8080_move_and_addsub_execute
// Execute stage for 8080 moves, add/subtract, carry and interrupt-enable ops.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries an opcode and the byte at the
//   current HL address (mem_data). Present mem_data for the HL shown on
//   next_hl of the previous result; it is ignored by forms that do not read M.
//   Output channel (out_valid / out_stall) returns one result per opcode:
//   memory write request, old HL, accumulator, flags, interrupt enable,
//   an implemented indication and the new HL.
//   Each opcode passes the input register, then the result register.
//   Throughput: one opcode per cycle while out_stall stays low; the whole
//   decode, 8-bit add/subtract and flag logic sits between the input
//   register and the result register.
//   The architectural state commits when an item moves into the result
//   register, so the next opcode sees it in the following cycle.
//   Reset clears the accumulator, B..L, flags, interrupt enable and both
//   pipeline valid bits.
//   When out_stall holds the result register full, the input register still
//   takes one more transfer; in_stall rises only when both are occupied.
// ----------------------------------------------------------------------------
module i8080_move_and_addsub_execute
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  opcode,
    input  logic [7:0]  mem_data,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        mem_write,
    output logic [15:0] mem_address,
    output logic [7:0]  mem_write_data,
    output logic [7:0]  acc_value,
    output logic        flag_carry,
    output logic        flag_aux,
    output logic        flag_zero,
    output logic        flag_sign,
    output logic        flag_parity,
    output logic        int_enable,
    output logic        implemented,
    output logic [15:0] next_hl
);

`include "i8080_move_and_addsub_execute_assert.svh"

    // Input register
    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic [7:0] opcode_reg;
    logic [7:0] mem_data_reg;

    // Result register
    logic                      out_valid_reg;
    logic                      out_valid_next;
    i8080mas_pkg::arch_state_t out_state_reg;
    i8080mas_pkg::exec_info_t  out_info_reg;

    logic                      in_xfer;
    logic                      advance;
    i8080mas_pkg::arch_state_t cur_state;
    i8080mas_pkg::arch_state_t exec_state;
    i8080mas_pkg::exec_info_t  exec_info;

    // Advance when the result register is empty or being drained
    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && out_valid_reg && out_stall;
    assign in_xfer  = in_valid && !in_stall;

    assign s1_valid_next  = in_xfer || (s1_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the input transfer
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            opcode_reg   <= opcode;
            mem_data_reg <= mem_data;
        end
    end

    // Capture the result; hold while stalled
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_state_reg <= exec_state;
            out_info_reg  <= exec_info;
        end
    end

    i8080mas_exec u_exec
    (
        .cur      (cur_state),
        .opcode   (opcode_reg),
        .mem_data (mem_data_reg),
        .nxt      (exec_state),
        .info     (exec_info)
    );

    i8080mas_state u_state
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .update     (advance),
        .state_next (exec_state),
        .state      (cur_state)
    );

    assign out_valid      = out_valid_reg;
    assign mem_write      = out_info_reg.mem_write;
    assign mem_address    = out_info_reg.mem_address;
    assign mem_write_data = out_info_reg.mem_write_data;
    assign implemented    = out_info_reg.implemented;
    assign acc_value      = out_state_reg.acc;
    assign flag_carry     = out_state_reg.flags.c;
    assign flag_aux       = out_state_reg.flags.ac;
    assign flag_zero      = out_state_reg.flags.z;
    assign flag_sign      = out_state_reg.flags.s;
    assign flag_parity    = out_state_reg.flags.p;
    assign int_enable     = out_state_reg.ie;
    assign next_hl        = {out_state_reg.gpr[i8080mas_pkg::REG_H[2:0]],
                             out_state_reg.gpr[i8080mas_pkg::REG_L[2:0]]};

    // Stall only with both stages full
    `I8080MAS_ASSERT_NOW(a_stall_needs_full, in_stall, s1_valid_reg && out_valid_reg)
    // State moves only when an item advances
    `I8080MAS_ASSERT_NEXT(a_state_hold, !advance, cur_state == $past(cur_state))
    // Unimplemented opcodes leave state untouched
    `I8080MAS_ASSERT_NEXT(a_unimpl_no_change, advance && !exec_info.implemented,
                          cur_state == $past(cur_state))
    // A memory write comes only from an executed opcode
    `I8080MAS_ASSERT_NOW(a_write_impl, out_valid_reg && mem_write, implemented)

endmodule

// ===== sv/i8080mas_exec.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i8080mas_exec
// Decode one opcode and compute the next architectural state and bus info.
// ----------------------------------------------------------------------------
module i8080mas_exec
(
    input  i8080mas_pkg::arch_state_t cur,
    input  logic [7:0]                opcode,
    input  logic [7:0]                mem_data,
    output i8080mas_pkg::arch_state_t nxt,
    output i8080mas_pkg::exec_info_t  info
);

    localparam logic [2:0] REG_H_IDX = i8080mas_pkg::REG_H[2:0];
    localparam logic [2:0] REG_L_IDX = i8080mas_pkg::REG_L[2:0];

    logic [7:0]            src_val;
    logic [15:0]           hl_cur;
    i8080mas_pkg::alu_op_t alu_op;
    logic                  is_sub;
    logic                  carry_in;
    logic                  cin_eff;
    logic [7:0]            b_op;
    logic [8:0]            sum9;
    logic [4:0]            lo5;
    logic [7:0]            alu_res;
    i8080mas_pkg::flags_t  alu_flags;

    assign hl_cur = {cur.gpr[REG_H_IDX], cur.gpr[REG_L_IDX]};

    // Source operand select
    always_comb
    begin
        unique case (opcode[2:0])
            i8080mas_pkg::OPND_ACC: src_val = cur.acc;
            i8080mas_pkg::OPND_MEM: src_val = mem_data;
            default:                src_val = cur.gpr[opcode[2:0]];
        endcase
    end

    // 8-bit adder; subtract as A + ~B + ~borrow
    always_comb
    begin
        alu_op   = i8080mas_pkg::alu_op_t'(opcode[4:3]);
        is_sub   = (alu_op == i8080mas_pkg::ALU_SUB) || (alu_op == i8080mas_pkg::ALU_SBB);
        carry_in = ((alu_op == i8080mas_pkg::ALU_ADC) || (alu_op == i8080mas_pkg::ALU_SBB))
                   & cur.flags.c;
        b_op     = is_sub ? ~src_val : src_val;
        cin_eff  = is_sub ? ~carry_in : carry_in;
        sum9     = {1'b0, cur.acc} + {1'b0, b_op} + {8'd0, cin_eff};
        lo5      = {1'b0, cur.acc[3:0]} + {1'b0, b_op[3:0]} + {4'd0, cin_eff};
        alu_res  = sum9[7:0];
        alu_flags.c  = sum9[8] ^ is_sub;
        alu_flags.ac = lo5[4];
        alu_flags.z  = (alu_res == 8'd0);
        alu_flags.s  = alu_res[7];
        alu_flags.p  = ~^alu_res;
    end

    // Decode and state update
    always_comb
    begin
        nxt                 = cur;
        info.mem_write      = 1'b0;
        info.mem_address    = hl_cur;
        info.mem_write_data = 8'd0;
        info.implemented    = 1'b1;

        priority if (opcode == i8080mas_pkg::OP_NOP)
        begin
            nxt = cur;
        end
        else if (opcode == i8080mas_pkg::OP_STC)
        begin
            nxt.flags.c = 1'b1;
        end
        else if (opcode == i8080mas_pkg::OP_CMC)
        begin
            nxt.flags.c = ~cur.flags.c;
        end
        else if (opcode == i8080mas_pkg::OP_DI)
        begin
            nxt.ie = 1'b0;
        end
        else if (opcode == i8080mas_pkg::OP_EI)
        begin
            nxt.ie = 1'b1;
        end
        else if ((opcode[7:6] == i8080mas_pkg::GRP_MOV) && (opcode != i8080mas_pkg::OP_HLT))
        begin
            unique case (opcode[5:3])
                i8080mas_pkg::OPND_MEM:
                begin
                    info.mem_write      = 1'b1;
                    info.mem_write_data = src_val;
                end
                i8080mas_pkg::OPND_ACC: nxt.acc = src_val;
                default:                nxt.gpr[opcode[5:3]] = src_val;
            endcase
        end
        else if (opcode[7:5] == i8080mas_pkg::GRP_ADDSUB)
        begin
            nxt.acc   = alu_res;
            nxt.flags = alu_flags;
        end
        else
        begin
            info.implemented = 1'b0;
        end
    end

endmodule

// ===== sv/i8080mas_state.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i8080mas_state
// Architectural state: accumulator, B..L, flags and interrupt enable.
// ----------------------------------------------------------------------------
module i8080mas_state
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      update,
    input  i8080mas_pkg::arch_state_t state_next,
    output i8080mas_pkg::arch_state_t state
);

    i8080mas_pkg::arch_state_t state_reg;

    // Commit the executed instruction's state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (update)
        begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

endmodule
